// ----- design/gasfp_pkg.sv -----
// Shared types, codes and helpers for the gas reading frame parser.
package gasfp_pkg;

   // Default limit on payload bytes per frame
   localparam int MAX_PAYLOAD_DEF = 10;

   // Special bytes of the frame
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] HEX_ALPHA  = 8'h37;
   localparam logic [3:0] NIB_TEN    = 4'hA;

   // Result beat layout
   localparam int READING_W = 32;
   localparam int RSP_DATA_W = 104;

   // Parse phase within a frame
   typedef enum logic [1:0] {
      PH_PAYLOAD = 2'd0,
      PH_HEX_HI  = 2'd1,
      PH_HEX_LO  = 2'd2,
      PH_SKIP    = 2'd3
   } phase_type;

   // Frame status codes, ordered by severity
   typedef enum logic [1:0] {
      ST_GOOD      = 2'd0,
      ST_SUM       = 2'd1,
      ST_MALFORMED = 2'd2
   } status_type;

   // Frame parser to statistics stage
   typedef struct packed {
      logic                   done;
      logic [READING_W-1:0]   reading;
      status_type             status;
   } frame_result_type;

   // Upper-case ASCII hex character for a nibble
   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] wide;
      wide = {4'h0, nib};
      if (nib >= NIB_TEN) begin
         hex_char = wide + HEX_ALPHA;
      end else begin
         hex_char = wide + CHAR_ZERO;
      end
   endfunction

endpackage

// ----- design/ascii_gas_reading_frame_parser_top.sv -----
// Gas sensor ASCII frame parser: one UART byte per input beat, one result beat per line feed.
// Each byte is captured in an input register and then processed by the frame parser;
// a line feed loads the result register. The block takes one byte per clock cycle as
// long as the result register is free or being drained, and a line feed beat passes the
// input register and then the result register to become its result beat. A result waiting
// on rsp_tready holds the parser only once the next byte is ready to be processed.
module ascii_gas_reading_frame_parser_top #(
   parameter int MAX_PAYLOAD = gasfp_pkg::MAX_PAYLOAD_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,  // [7:0] rx_byte
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [31:0] reading, [33:32] frame_status, [65:34] min_reading,
   // [97:66] max_reading, [98] stats_valid, [103:99] zero
   output logic [gasfp_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;
   logic        step_en;
   gasfp_pkg::frame_result_type result;

   // Process the held byte when the output register can take a result
   assign step_en    = in_valid_ff && (!rsp_tvalid || rsp_tready);
   assign req_tready = !in_valid_ff || step_en;

   always_comb begin
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (step_en) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // Input byte register
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
   end

   gasfp_frame #(
      .MAX_PAYLOAD(MAX_PAYLOAD)
   ) u_frame (
      .clock   (clock),
      .reset   (reset),
      .byte_en (step_en),
      .rx_byte (in_byte_ff),
      .result  (result)
   );

   gasfp_stats u_stats (
      .clock      (clock),
      .reset      (reset),
      .step_en    (step_en),
      .result     (result),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ----- design/gasfp_frame.sv -----
// Per-frame parse state: payload fold, checksum check and frame status.
module gasfp_frame #(
   parameter int MAX_PAYLOAD = gasfp_pkg::MAX_PAYLOAD_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        byte_en,
   input  logic [7:0]                  rx_byte,
   output gasfp_pkg::frame_result_type result
);

   localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PAYLOAD);

   gasfp_pkg::phase_type  phase_ff, phase_in;
   gasfp_pkg::status_type bad_ff, bad_in;
   logic [7:0]            sum_ff, sum_in;
   logic [31:0]           accum_ff, accum_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  hi_ok_ff, hi_ok_in;

   logic                  is_lf;
   logic [7:0]            want;
   logic [31:0]           digit;

   assign is_lf = (rx_byte == gasfp_pkg::CHAR_LF);
   assign want  = 8'h00 - sum_ff;
   assign digit = {24'h0, rx_byte} - {24'h0, gasfp_pkg::CHAR_ZERO};

   // Next frame state for one byte
   always_comb begin
      phase_in = phase_ff;
      bad_in   = bad_ff;
      sum_in   = sum_ff;
      accum_in = accum_ff;
      count_in = count_ff;
      hi_ok_in = hi_ok_ff;
      if (is_lf) begin
         phase_in = gasfp_pkg::PH_PAYLOAD;
         bad_in   = gasfp_pkg::ST_GOOD;
         sum_in   = 8'h00;
         accum_in = 32'h0;
         count_in = '0;
         hi_ok_in = 1'b0;
      end else begin
         unique case (phase_ff)
            gasfp_pkg::PH_PAYLOAD: begin
               if (rx_byte == gasfp_pkg::CHAR_TAB) begin
                  if (count_ff == '0) begin
                     bad_in = gasfp_pkg::ST_MALFORMED;
                  end
                  phase_in = gasfp_pkg::PH_HEX_HI;
               end else if (count_ff >= CNT_MAX) begin
                  bad_in = gasfp_pkg::ST_MALFORMED;
               end else begin
                  sum_in   = sum_ff + rx_byte;
                  accum_in = (accum_ff << 3) + (accum_ff << 1) + digit;
                  count_in = count_ff + 1'b1;
               end
            end
            gasfp_pkg::PH_HEX_HI: begin
               hi_ok_in = (rx_byte == gasfp_pkg::hex_char(want[7:4]));
               phase_in = gasfp_pkg::PH_HEX_LO;
            end
            gasfp_pkg::PH_HEX_LO: begin
               if (!(hi_ok_ff && rx_byte == gasfp_pkg::hex_char(want[3:0])) &&
                   bad_ff == gasfp_pkg::ST_GOOD) begin
                  bad_in = gasfp_pkg::ST_SUM;
               end
               phase_in = gasfp_pkg::PH_SKIP;
            end
            default: begin
            end
         endcase
      end
   end

   // Result of a line feed
   always_comb begin
      result.done    = byte_en && is_lf;
      result.reading = accum_ff;
      if (phase_ff != gasfp_pkg::PH_SKIP) begin
         result.status = gasfp_pkg::ST_MALFORMED;
      end else begin
         result.status = bad_ff;
      end
   end

   // Frame state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= gasfp_pkg::PH_PAYLOAD;
         bad_ff   <= gasfp_pkg::ST_GOOD;
         sum_ff   <= 8'h00;
         accum_ff <= 32'h0;
         count_ff <= '0;
         hi_ok_ff <= 1'b0;
      end else if (byte_en) begin
         phase_ff <= phase_in;
         bad_ff   <= bad_in;
         sum_ff   <= sum_in;
         accum_ff <= accum_in;
         count_ff <= count_in;
         hi_ok_ff <= hi_ok_in;
      end
   end

endmodule

// ----- design/gasfp_stats.sv -----
// Running min/max of good readings and the result output register.
module gasfp_stats (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  step_en,
   input  gasfp_pkg::frame_result_type           result,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [gasfp_pkg::RSP_DATA_W-1:0]      rsp_tdata
);

   logic [31:0] low_ff, low_in;
   logic [31:0] high_ff, high_in;
   logic        any_ff, any_in;
   logic        out_valid_ff, out_valid_in;
   logic [gasfp_pkg::RSP_DATA_W-1:0] out_data_ff, out_data_in;
   logic        load;
   logic        good;

   assign load = step_en && result.done;
   assign good = (result.status == gasfp_pkg::ST_GOOD);

   // Min/max update for a good reading
   always_comb begin
      low_in  = low_ff;
      high_in = high_ff;
      any_in  = any_ff;
      if (good) begin
         if (!any_ff) begin
            low_in  = result.reading;
            high_in = result.reading;
            any_in  = 1'b1;
         end else begin
            if (result.reading > high_ff) begin
               high_in = result.reading;
            end
            if (result.reading < low_ff) begin
               low_in = result.reading;
            end
         end
      end
   end

   // Result beat and its valid flag
   always_comb begin
      out_data_in = {5'b0, any_in, high_in, low_in, result.status, result.reading};
      if (load) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff       <= 32'h0;
         high_ff      <= 32'h0;
         any_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (load) begin
            low_ff  <= low_in;
            high_ff <= high_in;
            any_ff  <= any_in;
         end
      end
   end

   // Payload register, no reset needed
   always_ff @(posedge clock) begin
      if (load) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule
